// ===== hdl/npcm_pkg.sv =====
// shared constants and types for the nearest palette color mapper
// no dependencies; imported by every module of the block
package npcm_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int ADDR_W = $clog2(PALETTE_ENTRIES);
  localparam int CNT_W  = $clog2(PALETTE_ENTRIES + 1);
  localparam int CH_W   = 8;
  localparam int ENTRY_W = 3 * CH_W;
  localparam int IDX_W  = 8;
  localparam int DIST_W = 18;
  localparam int SQ_W   = 2 * CH_W;

  localparam int CFG_DATA_W  = 9;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_PALETTE_COUNT   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PALETTE_IS_4BIT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FALLBACK_MODE   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PLANE_DEPTH     = 2'd3;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  localparam logic MODE_CHUNKY = 1'b0;
  localparam logic MODE_PLANAR = 1'b1;

  localparam logic [3:0] DEPTH_RESET = 4'd8;

  // one candidate entry handed to the distance unit
  typedef struct packed {
    logic              start;
    logic              valid;
    logic              last;
    logic [ADDR_W-1:0] idx;
  } search_ctl_t;

  // outcome of one search
  typedef struct packed {
    logic              done;
    logic [IDX_W-1:0]  best_idx;
    logic [DIST_W-1:0] best_dist;
  } search_res_t;

endpackage

// ===== hdl/npcm_palette_ram.sv =====
// palette store: one write port, one registered read port
// depends on npcm_pkg
module npcm_palette_ram
  import npcm_pkg::*;
(
  input  logic               clk,
  input  logic               we,
  input  logic [ADDR_W-1:0]  waddr,
  input  logic [ENTRY_W-1:0] wdata,
  input  logic               re,
  input  logic [ADDR_W-1:0]  raddr,
  output logic [ENTRY_W-1:0] rdata
);

  logic [ENTRY_W-1:0] mem [PALETTE_ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/npcm_dist_unit.sv =====
// shared distance unit: one palette entry per cycle, widen, diff, square-sum, compare
// depends on npcm_pkg; entry data arrives from the palette ram in the cycle after its control
module npcm_dist_unit
  import npcm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  search_ctl_t        ctl,
  input  logic [ENTRY_W-1:0] entry,
  input  logic [CH_W-1:0]    red,
  input  logic [CH_W-1:0]    green,
  input  logic [CH_W-1:0]    blue,
  input  logic               is_4bit,
  output search_res_t        res
);

  function automatic logic [CH_W-1:0] widen(input logic [CH_W-1:0] p, input logic en);
    widen = en ? (p | (p >> 4)) : p;
  endfunction

  function automatic logic [CH_W-1:0] absdiff(input logic [CH_W-1:0] a,
                                              input logic [CH_W-1:0] b);
    absdiff = (a >= b) ? (a - b) : (b - a);
  endfunction

  // stage 1 aligns with ram read data
  logic              v1, last1;
  logic [ADDR_W-1:0] idx1;
  // stage 2: absolute channel differences
  logic              v2, last2;
  logic [ADDR_W-1:0] idx2;
  logic [CH_W-1:0]   dr2, dg2, db2;
  // stage 3: squared distance
  logic              v3, last3;
  logic [ADDR_W-1:0] idx3;
  logic [DIST_W-1:0] dist3;

  logic [CH_W-1:0] er, eg, eb;
  logic [SQ_W-1:0] sr, sg, sb;

  logic [IDX_W-1:0]  best_idx;
  logic [DIST_W-1:0] best_dist;
  logic              done;

  always_comb begin
    er = widen(entry[3*CH_W-1:2*CH_W], is_4bit);
    eg = widen(entry[2*CH_W-1:CH_W], is_4bit);
    eb = widen(entry[CH_W-1:0], is_4bit);
    sr = dr2 * dr2;
    sg = dg2 * dg2;
    sb = db2 * db2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      done <= 1'b0;
    end else begin
      v1 <= ctl.valid;
      v2 <= v1;
      v3 <= v2;
      done <= v3 && last3;
    end
  end

  always_ff @(posedge clk) begin
    last1 <= ctl.last;
    idx1  <= ctl.idx;
    last2 <= last1;
    idx2  <= idx1;
    dr2   <= absdiff(red, er);
    dg2   <= absdiff(green, eg);
    db2   <= absdiff(blue, eb);
    last3 <= last2;
    idx3  <= idx2;
    dist3 <= DIST_W'(sr) + DIST_W'(sg) + DIST_W'(sb);
  end

  // strict less keeps the lowest index on a tie
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      best_dist <= '1;
      best_idx  <= '0;
    end else if (v3 && (dist3 < best_dist)) begin
      best_dist <= dist3;
      best_idx  <= IDX_W'(idx3);
    end
  end

  always_comb begin
    res.done      = done;
    res.best_idx  = best_idx;
    res.best_dist = best_dist;
  end

endmodule

// ===== hdl/npcm_quantizer.sv =====
// fallback quantizer used when no palette is loaded: 3-3-2 chunky or depth-based planar
// depends on npcm_pkg
module npcm_quantizer
  import npcm_pkg::*;
(
  input  logic [CH_W-1:0]  red,
  input  logic [CH_W-1:0]  green,
  input  logic [CH_W-1:0]  blue,
  input  logic             mode,
  input  logic [3:0]       depth,
  output logic [IDX_W-1:0] color_index
);

  logic [3:0]      d;
  logic [2:0]      sh;
  logic [2:0]      r_sh, g_sh;
  logic [15:0]     rr, gg, bb, mix;
  logic [IDX_W:0]  lim;
  logic [IDX_W-1:0] planar;

  always_comb begin
    if (depth == 4'd0) begin
      d = 4'd1;
    end else if (depth > 4'd8) begin
      d = 4'd8;
    end else begin
      d = depth;
    end
    sh = 3'(4'd8 - d);
    // shift amounts 2d/3 and d/3 for depths one to eight
    case (d)
      4'd1:    begin r_sh = 3'd0; g_sh = 3'd0; end
      4'd2:    begin r_sh = 3'd1; g_sh = 3'd0; end
      4'd3:    begin r_sh = 3'd2; g_sh = 3'd1; end
      4'd4:    begin r_sh = 3'd2; g_sh = 3'd1; end
      4'd5:    begin r_sh = 3'd3; g_sh = 3'd1; end
      4'd6:    begin r_sh = 3'd4; g_sh = 3'd2; end
      4'd7:    begin r_sh = 3'd4; g_sh = 3'd2; end
      default: begin r_sh = 3'd5; g_sh = 3'd2; end
    endcase
    rr  = {8'd0, red >> sh} << r_sh;
    gg  = {8'd0, green >> sh} << g_sh;
    bb  = {8'd0, blue >> sh};
    mix = rr | gg | bb;
    lim = (9'd1 << d) - 9'd1;
    planar = ({1'b0, mix[IDX_W-1:0]} > lim) ? lim[IDX_W-1:0] : mix[IDX_W-1:0];
    color_index = (mode == MODE_CHUNKY) ? {red[7:5], green[7:5], blue[7:6]} : planar;
  end

endmodule

// ===== hdl/nearest_palette_color_mapper.sv =====
// top level of the nearest palette color mapper: sequencer, config registers, output register
// depends on npcm_pkg, npcm_palette_ram, npcm_dist_unit, npcm_quantizer
//
// input stream s_*: tuser is the kind (0 palette write, 1 pixel); tdata carries
// entry_index, red, green, blue from the lowest byte up. a palette write is
// stored at the accepting edge and gives no result; the block stays ready.
// a pixel gives one result on m_*: tdata holds color_index (7:0) and
// best_distance (25:8), tuser holds used_fallback.
// with palette_count zero the fallback quantizer answers and the result is
// registered once the done state finds the output register free. otherwise
// the single distance unit walks n entries (n is the count, capped at 256),
// one per cycle, through the ram read port; the drain state waits for its
// done flag, the done state registers the result, and s_tready stays low.
// s_tready is high in idle even while a result waits in the output register;
// a stalled receiver holds the result, and the next pixel waits before its
// own result until the register frees up.
// cfg_we writes register cfg_index from cfg_data at once; write only while idle.
// rst (synchronous) clears control state and loads register reset values;
// palette contents are undefined until written.
module nearest_palette_color_mapper
  import npcm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [31:0]            s_tdata,   // entry_index, red, green, blue
  input  logic                   s_tuser,   // kind
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [31:0]            m_tdata,   // color_index, best_distance, zero pad
  output logic                   m_tuser,   // used_fallback
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  logic [1:0] state, state_next;

  logic [CNT_W-1:0] palette_count;
  logic             palette_is_4bit;
  logic             fallback_mode;
  logic [3:0]       plane_depth;

  logic [CH_W-1:0]  red, green, blue;
  logic             fallback;
  logic [CNT_W-1:0] issue_cnt;
  logic [CNT_W-1:0] n;

  logic             accept, write_acc, pixel_acc;
  logic             out_free;
  search_ctl_t      ctl;
  search_res_t      res;
  logic [ENTRY_W-1:0] ram_q;
  logic [IDX_W-1:0] quant_idx;

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign write_acc = accept && (s_tuser == KIND_WRITE);
  assign pixel_acc = accept && (s_tuser == KIND_PIXEL);
  assign out_free  = !m_tvalid || m_tready;
  assign n = (palette_count > CNT_W'(PALETTE_ENTRIES)) ? CNT_W'(PALETTE_ENTRIES)
                                                      : palette_count;

  always_comb begin
    ctl.start = pixel_acc;
    ctl.valid = (state == ST_SEARCH);
    ctl.last  = (issue_cnt == n - CNT_W'(1));
    ctl.idx   = issue_cnt[ADDR_W-1:0];
  end

  npcm_palette_ram u_ram (
    .clk   (clk),
    .we    (write_acc),
    .waddr (s_tdata[ADDR_W-1:0]),
    .wdata ({s_tdata[15:8], s_tdata[23:16], s_tdata[31:24]}),
    .re    (ctl.valid),
    .raddr (ctl.idx),
    .rdata (ram_q)
  );

  npcm_dist_unit u_dist (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .entry   (ram_q),
    .red     (red),
    .green   (green),
    .blue    (blue),
    .is_4bit (palette_is_4bit),
    .res     (res)
  );

  npcm_quantizer u_quant (
    .red         (red),
    .green       (green),
    .blue        (blue),
    .mode        (fallback_mode),
    .depth       (plane_depth),
    .color_index (quant_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      palette_count   <= '0;
      palette_is_4bit <= 1'b0;
      fallback_mode   <= MODE_CHUNKY;
      plane_depth     <= DEPTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PALETTE_COUNT:   palette_count   <= cfg_data;
        CFG_PALETTE_IS_4BIT: palette_is_4bit <= cfg_data[0];
        CFG_FALLBACK_MODE:   fallback_mode   <= cfg_data[0];
        CFG_PLANE_DEPTH:     plane_depth     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (pixel_acc) begin
          state_next = (n == '0) ? ST_DONE : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (ctl.last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (res.done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      issue_cnt <= '0;
    end else begin
      state <= state_next;
      if (pixel_acc) begin
        issue_cnt <= '0;
      end else if (state == ST_SEARCH) begin
        issue_cnt <= issue_cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_acc) begin
      red      <= s_tdata[15:8];
      green    <= s_tdata[23:16];
      blue     <= s_tdata[31:24];
      fallback <= (n == '0);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_tuser <= fallback;
      if (fallback) begin
        m_tdata <= {6'd0, DIST_W'(0), quant_idx};
      end else begin
        m_tdata <= {6'd0, res.best_dist, res.best_idx};
      end
    end
  end

endmodule

// ===== hdl/npcm_checker.sv =====
// port-level checks for the nearest palette color mapper, bound to the top level
// depends on npcm_pkg and nearest_palette_color_mapper
module npcm_checker
  import npcm_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // a pixel keeps the block busy for at least the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == KIND_PIXEL |=> !s_tready)
    else $error("ready right after a pixel transaction");

  a_fb_dist: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[25:8] == 18'd0)
    else $error("fallback result with nonzero distance");

  a_dist_max: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[25:8] <= 18'd195075 && m_tdata[31:26] == 6'd0)
    else $error("search distance out of range");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind nearest_palette_color_mapper npcm_checker u_npcm_checker (.*);

// ===== sim/nearest_palette_color_mapper_tb.sv =====
// testbench for nearest_palette_color_mapper: directed and random palette/pixel traffic
// depends on npcm_pkg and the nearest_palette_color_mapper rtl; results are checked
// against a nearest-color predictor kept in this file
module nearest_palette_color_mapper_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import npcm_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int DRAIN_CYCLES  = PALETTE_ENTRIES + 40;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 200;

  typedef struct packed {
    logic [IDX_W-1:0]  color_index;
    logic [DIST_W-1:0] best_distance;
    logic              used_fallback;
  } mapped_pixel_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [31:0]            s_tdata = '0;   // entry_index, red, green, blue
  logic                   s_tuser = 1'b0; // kind
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [31:0]            m_tdata;        // color_index, best_distance, zero pad
  logic                   m_tuser;        // used_fallback
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // predictor state: palette copy and register copies
  logic [ENTRY_W-1:0]     palette_copy [PALETTE_ENTRIES];
  bit                     entry_loaded [PALETTE_ENTRIES];
  logic [CFG_DATA_W-1:0]  count_reg = '0;
  logic                   is_4bit_reg = 1'b0;
  logic                   mode_reg = MODE_CHUNKY;
  logic [3:0]             depth_reg = DEPTH_RESET;

  mapped_pixel_t expected_pixels [$];
  int  mismatches = 0;
  int  cycle_count = 0;
  int  items_sent = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_active = 1'b0;
  event hold_start;

  nearest_palette_color_mapper i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("nearest_palette_color_mapper verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [7:0] widen_channel(logic [7:0] p);
    return is_4bit_reg ? (p | (p >> 4)) : p;
  endfunction

  function automatic logic [7:0] quantize_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int d, sh, idx, lim;
    if (mode_reg == MODE_CHUNKY) return {r[7:5], g[7:5], b[7:6]};
    d = depth_reg;
    if (d < 1) d = 1;
    if (d > 8) d = 8;
    sh = 8 - d;
    idx = ((int'(r) >> sh) << (d * 2 / 3)) | ((int'(g) >> sh) << (d / 3)) | (int'(b) >> sh);
    idx = idx & 255;
    lim = (1 << d) - 1;
    if (idx > lim) idx = lim;
    return idx[7:0];
  endfunction

  function automatic mapped_pixel_t predict_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    mapped_pixel_t res;
    int n, dr, dg, db, sq_dist, best_dist, best_idx;
    logic [ENTRY_W-1:0] e;
    n = (count_reg > PALETTE_ENTRIES) ? PALETTE_ENTRIES : int'(count_reg);
    if (n == 0) begin
      res.color_index   = quantize_pixel(r, g, b);
      res.best_distance = '0;
      res.used_fallback = 1'b1;
      return res;
    end
    best_dist = 32'h7fff_ffff;
    best_idx  = 0;
    for (int j = 0; j < n; j++) begin
      e  = palette_copy[j];
      dr = int'(r) - int'(widen_channel(e[23:16]));
      dg = int'(g) - int'(widen_channel(e[15:8]));
      db = int'(b) - int'(widen_channel(e[7:0]));
      sq_dist = dr * dr + dg * dg + db * db;
      // strict compare keeps the lowest index on a tie
      if (sq_dist < best_dist) begin
        best_dist = sq_dist;
        best_idx  = j;
      end
    end
    res.color_index   = best_idx[IDX_W-1:0];
    res.best_distance = best_dist[DIST_W-1:0];
    res.used_fallback = 1'b0;
    return res;
  endfunction

  // ---------------------------------------------------------------- result side

  always @(negedge clk) m_tready <= !hold_active && ($urandom_range(0, 99) >= recv_idle_pct);

  // long receiver hold-off, counted here so the sender keeps pushing meanwhile
  initial forever begin
    @(hold_start);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  always @(posedge clk) begin : result_check
    mapped_pixel_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_pixels.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: index %0d dist %0d fallback %0b",
                   m_tdata[7:0], m_tdata[25:8], m_tuser);
        mismatches++;
      end else begin
        want = expected_pixels.pop_front();
        if (m_tdata[7:0] !== want.color_index || m_tdata[25:8] !== want.best_distance ||
            m_tuser !== want.used_fallback) begin
          if (mismatches < 10)
            $display("mismatch: expected index %0d dist %0d fallback %0b, got %0d %0d %0b",
                     want.color_index, want.best_distance, want.used_fallback,
                     m_tdata[7:0], m_tdata[25:8], m_tuser);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus helpers

  // entered just after a falling edge; returns just after the falling edge that follows acceptance
  task automatic send_item(input logic kind, input logic [7:0] slot,
                           input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {b, g, r, slot};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (kind == KIND_WRITE) begin
      palette_copy[slot] = {r, g, b};
      entry_loaded[slot] = 1'b1;
    end else begin
      expected_pixels.push_back(predict_pixel(r, g, b));
    end
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    send_item(KIND_PIXEL, 8'($urandom_range(0, 255)), r, g, b);
  endtask

  function automatic logic [7:0] rand_channel(bit coarse);
    int pick;
    pick = $urandom_range(0, 9);
    if (coarse) return 8'($urandom_range(0, 3) * 85);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hff;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] nudge(logic [7:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 8)) - 4;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // palette entries below the searched count must hold a written value
  task automatic load_entries_below(input int n, input bit coarse);
    for (int j = 0; j < n && j < PALETTE_ENTRIES; j++)
      if (!entry_loaded[j])
        send_item(KIND_WRITE, 8'(j), rand_channel(coarse), rand_channel(coarse),
                  rand_channel(coarse));
  endtask

  // registers change only with no transaction in flight
  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(negedge clk);
    case (idx)
      CFG_PALETTE_COUNT:   count_reg   = CFG_DATA_W'(value);
      CFG_PALETTE_IS_4BIT: is_4bit_reg = value[0];
      CFG_FALLBACK_MODE:   mode_reg    = value[0];
      CFG_PLANE_DEPTH:     depth_reg   = value[3:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int count_val, input bit is4, input bit mode,
                                input int depth_val);
    settle();
    write_reg(CFG_PALETTE_COUNT, count_val);
    write_reg(CFG_PALETTE_IS_4BIT, is4);
    write_reg(CFG_FALLBACK_MODE, mode);
    write_reg(CFG_PLANE_DEPTH, depth_val);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------- tests

  // reset values first: no palette, chunky quantizer
  task automatic test_chunky_fallback();
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hff);
    apply_settings(0, 1'b0, MODE_CHUNKY, DEPTH_RESET);
    send_pixel(8'ha0, 8'h5f, 8'hc3);
  endtask

  // depth 0 acts as 1, above 8 as 8; the shift-and-or result clamps to the depth
  task automatic test_planar_fallback();
    int depths [6] = '{0, 1, 3, 8, 9, 511};
    foreach (depths[k]) begin
      apply_settings(0, 1'b0, MODE_PLANAR, depths[k]);
      send_pixel(8'hff, 8'hff, 8'hff);
    end
    apply_settings(0, 1'b0, MODE_PLANAR, 5);
    send_pixel(8'ha5, 8'h3c, 8'h81);
  endtask

  // exact hits, extremes, and ties that must keep the lower index
  task automatic test_palette_search();
    send_item(KIND_WRITE, 8'd0, 8'h00, 8'h00, 8'h00);
    send_item(KIND_WRITE, 8'd1, 8'hff, 8'hff, 8'hff);
    send_item(KIND_WRITE, 8'd2, 8'h80, 8'h80, 8'h80);
    send_item(KIND_WRITE, 8'd3, 8'h80, 8'h80, 8'h80);
    apply_settings(4, 1'b0, MODE_CHUNKY, DEPTH_RESET);
    send_pixel(8'h80, 8'h80, 8'h80);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'h40, 8'h40, 8'h40);
  endtask

  task automatic test_4bit_widen();
    apply_settings(4, 1'b1, MODE_PLANAR, DEPTH_RESET);
    send_pixel(8'h88, 8'h88, 8'h88);
    send_pixel(8'h0f, 8'h0f, 8'h0f);
  endtask

  // full store, with a count above the store size that must saturate
  task automatic test_full_palette();
    load_entries_below(PALETTE_ENTRIES, 1'b0);
    apply_settings(511, 1'b0, MODE_CHUNKY, DEPTH_RESET);
    send_pixel(palette_copy[255][23:16], palette_copy[255][15:8], palette_copy[255][7:0]);
    repeat (3) send_pixel(rand_channel(0), rand_channel(0), rand_channel(0));
    apply_settings(PALETTE_ENTRIES, 1'b1, MODE_PLANAR, 4);
    repeat (2) send_pixel(rand_channel(0), rand_channel(0), rand_channel(0));
  endtask

  // receiver holds off while the sender keeps offering, so the block stalls its input
  task automatic test_backpressure();
    int saved_pct;
    saved_pct = send_idle_pct;
    send_idle_pct = 0;
    apply_settings(0, 1'b0, MODE_PLANAR, 6);
    -> hold_start;
    repeat (16) send_pixel(rand_channel(0), rand_channel(0), rand_channel(0));
    load_entries_below(3, 1'b0);
    apply_settings(3, 1'b0, MODE_CHUNKY, DEPTH_RESET);
    -> hold_start;
    repeat (8) send_pixel(rand_channel(0), rand_channel(0), rand_channel(0));
    send_idle_pct = saved_pct;
  endtask

  // one random setting followed by a burst of mixed palette writes and pixels
  task automatic run_segment();
    int pick, count_val, n, burst, j;
    bit coarse;
    logic [7:0] r, g, b;
    pick = $urandom_range(0, 99);
    if (pick < 15)      count_val = 0;
    else if (pick < 19) count_val = $urandom_range(PALETTE_ENTRIES, 511);
    else if (pick < 60) count_val = $urandom_range(1, 4);
    else                count_val = $urandom_range(5, 24);
    n = (count_val > PALETTE_ENTRIES) ? PALETTE_ENTRIES : count_val;
    burst = (n > 32) ? 6 : $urandom_range(10, 30);
    coarse = $urandom_range(0, 1);
    load_entries_below(n, coarse);
    apply_settings(count_val, $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 15));
    repeat (burst) begin
      if ($urandom_range(0, 3) == 0) begin
        send_item(KIND_WRITE, 8'($urandom_range(0, 255)), rand_channel(coarse),
                  rand_channel(coarse), rand_channel(coarse));
      end else begin
        if (n > 0 && $urandom_range(0, 2) == 0) begin
          j = $urandom_range(0, n - 1);
          r = nudge(palette_copy[j][23:16]);
          g = nudge(palette_copy[j][15:8]);
          b = nudge(palette_copy[j][7:0]);
        end else begin
          r = rand_channel(coarse);
          g = rand_channel(coarse);
          b = rand_channel(coarse);
        end
        send_pixel(r, g, b);
      end
    end
  endtask

  task automatic test_random_traffic(input int sender_pct, input int receiver_pct);
    int start;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    start = items_sent;
    while (items_sent - start < PHASE_ITEMS) run_segment();
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    send_idle_pct = 28;
    recv_idle_pct = 80;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_chunky_fallback();
    test_planar_fallback();
    test_palette_search();
    test_4bit_widen();
    test_random_traffic(28, 80);
    test_full_palette();
    test_backpressure();
    test_random_traffic(80, 28);
    test_random_traffic(0, 0);

    s_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("nearest_palette_color_mapper verification clean");
    end else begin
      $display("nearest_palette_color_mapper verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/npcm_pkg.sv
hdl/npcm_palette_ram.sv
hdl/npcm_dist_unit.sv
hdl/npcm_quantizer.sv
hdl/nearest_palette_color_mapper.sv
hdl/npcm_checker.sv
sim/nearest_palette_color_mapper_tb.sv
